// ===== hw/rtl/jas_pkg.sv =====
package jas_pkg;

   localparam int JOINT_COUNT = 6;
   localparam int FRAC_BITS   = 12;
   localparam int DATA_W      = 16;
   localparam int WEIGHT_W    = 13;
   localparam int AMT_W       = 13;
   localparam int INDEX_W     = 3;
   localparam int SBIAS_W     = 48;
   localparam int GBIAS_W     = 64;
   localparam int CSR_DATA_W  = 64;

   localparam int ONE_Q  = 1 << FRAC_BITS;
   localparam int HALF_Q = 1 << (FRAC_BITS - 1);

   // Gripper angles that bound the grasp ramp, and the gripper clamp window.
   localparam int GRASP_OPEN  = -(((1100 << FRAC_BITS) + 500) / 1000);
   localparam int GRASP_CLOSE = -(((50 << FRAC_BITS) + 500) / 1000);
   localparam int GRIP_MIN    = -(((1750 << FRAC_BITS) + 500) / 1000);
   localparam int GRIP_MAX    = ((100 << FRAC_BITS) + 500) / 1000;
   localparam int GRASP_DEN   = GRASP_CLOSE - GRASP_OPEN;
   localparam int GRASP_HALF  = GRASP_DEN / 2;
   // Grasp acts when amount * 1000 exceeds one, i.e. amount above this value.
   localparam int GRASP_THRESH = ONE_Q / 1000;

   // Reciprocal of the ramp span for the divide-by-constant.
   localparam int      RECIP_SHIFT = 32;
   localparam int      RECIP_W     = 20;
   localparam longint  RECIP       = (longint'(1) << RECIP_SHIFT) / GRASP_DEN;
   localparam int      NUM_W       = AMT_W + FRAC_BITS;

   // Operation codes of an input transaction.
   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // Configuration register indexes.
   localparam logic [INDEX_W-1:0] REG_WEIGHT_MAIN   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_WEIGHT_JOINT1 = 3'd1;
   localparam logic [INDEX_W-1:0] REG_WEIGHT_JOINT3 = 3'd2;
   localparam logic [INDEX_W-1:0] REG_WEIGHT_GRIP   = 3'd3;
   localparam logic [INDEX_W-1:0] REG_STATIC_BIAS   = 3'd4;
   localparam logic [INDEX_W-1:0] REG_GRASP_BIAS    = 3'd5;

   typedef logic [JOINT_COUNT-1:0][DATA_W-1:0] joint_vec_type;

   typedef struct packed {
      logic          load;
      joint_vec_type joint;
      logic [DATA_W-1:0] grip;
   } item_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight_main;
      logic [WEIGHT_W-1:0] weight_joint1;
      logic [WEIGHT_W-1:0] weight_joint3;
      logic [WEIGHT_W-1:0] weight_grip;
      logic [SBIAS_W-1:0] static_bias;
      logic [GBIAS_W-1:0] grasp_bias;
   } cfg_type;

endpackage

// ===== hw/rtl/jas_front.sv =====
module jas_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  logic                   in_operation,
   input  jas_pkg::joint_vec_type in_joint,
   input  logic [jas_pkg::DATA_W-1:0] in_grip,
   output logic                   head_valid,
   output jas_pkg::item_type      head,
   input  logic                   head_pop
);

   // Two-entry queue between the input channel and the filter engine.
   jas_pkg::item_type entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   jas_pkg::item_type entry;

   assign in_stall   = (count_ff == 2'd2);
   assign push       = in_valid && !in_stall;
   assign head_valid = (count_ff != 2'd0);
   assign head       = entries_ff[rd_ptr_ff];

   always_comb begin
      entry.load  = (in_operation == jas_pkg::OP_LOAD);
      entry.joint = in_joint;
      entry.grip  = in_grip;
      wr_ptr_in   = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in   = head_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in    = count_ff + {1'b0, push} - {1'b0, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

// ===== hw/rtl/jas_back.sv =====
module jas_back (
   input  logic                   clock,
   input  logic                   reset,
   input  jas_pkg::cfg_type       cfg,
   input  logic                   head_valid,
   input  jas_pkg::item_type      head,
   output logic                   head_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output jas_pkg::joint_vec_type rsp_joint,
   output logic [jas_pkg::DATA_W-1:0] rsp_grip,
   output logic [jas_pkg::AMT_W-1:0]  rsp_amount
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   // Sequencer steps: gripper first so the grasp divide overlaps the joints.
   localparam logic [3:0] STEP_GRIP        = 4'd0;
   localparam logic [3:0] STEP_J_FIRST     = 4'd1;
   localparam logic [3:0] STEP_DIV         = 4'd1;
   localparam logic [3:0] STEP_AMT         = 4'd2;
   localparam logic [3:0] STEP_J_LAST      = 4'(jas_pkg::JOINT_COUNT);
   localparam logic [3:0] STEP_GRASP_FIRST = 4'(jas_pkg::JOINT_COUNT + 1);
   localparam logic [3:0] STEP_FINAL       = 4'(jas_pkg::JOINT_COUNT + 4);

   localparam logic [jas_pkg::WEIGHT_W-1:0] ONE_W = jas_pkg::WEIGHT_W'(jas_pkg::ONE_Q);
   localparam logic signed [16:0] OPEN17  = 17'(jas_pkg::GRASP_OPEN);
   localparam logic signed [15:0] OPEN16  = 16'(jas_pkg::GRASP_OPEN);
   localparam logic signed [15:0] CLOSE16 = 16'(jas_pkg::GRASP_CLOSE);
   localparam logic signed [18:0] GMIN19  = 19'(jas_pkg::GRIP_MIN);
   localparam logic signed [18:0] GMAX19  = 19'(jas_pkg::GRIP_MAX);

   function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   logic       st_ff, st_in;
   logic [3:0] step_ff, step_in;
   jas_pkg::joint_vec_type x_j_ff, x_j_in;
   logic [15:0] x_g_ff, x_g_in;
   jas_pkg::joint_vec_type filt_j_ff, filt_j_in;
   logic [15:0] filt_g_ff, filt_g_in;
   logic        jvalid_ff, jvalid_in;
   logic        gvalid_ff, gvalid_in;
   jas_pkg::joint_vec_type res_j_ff, res_j_in;
   logic [44:0] div_prod_ff, div_prod_in;
   logic [jas_pkg::AMT_W-1:0] amt_ff, amt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   jas_pkg::joint_vec_type rsp_j_ff, rsp_j_in;
   logic [15:0] rsp_g_ff, rsp_g_in;
   logic [jas_pkg::AMT_W-1:0] rsp_amt_ff, rsp_amt_in;

   // Shared blend datapath: y*ONE + w*(x - y), rounded and floored.
   logic [2:0]  j_idx;
   logic [jas_pkg::WEIGHT_W-1:0] w_raw, w_eff;
   logic signed [15:0] x_sel, y_sel;
   logic signed [16:0] diff;
   logic signed [30:0] bprod;
   logic signed [31:0] bacc, bshift;
   logic signed [15:0] blend_val, grip_new, joint_new;
   logic signed [15:0] sbias;
   logic signed [15:0] joint_biased;

   // Grasp amount divide and grasp bias datapath.
   logic signed [16:0] gd;
   logic [jas_pkg::NUM_W-1:0] num;
   logic [jas_pkg::AMT_W-1:0] q_est, q_fix, amt_calc;
   logic [25:0] rem;
   logic [1:0]  gb_idx;
   logic [2:0]  g_idx;
   logic signed [15:0] gbias;
   logic signed [29:0] tprod;
   logic signed [30:0] tsum, tshift;
   logic signed [17:0] term;
   logic        active;
   logic signed [15:0] joint_grasp;
   logic signed [18:0] grip_sum;
   logic signed [15:0] grip_final;

   always_comb begin
      j_idx = 3'(step_ff - STEP_J_FIRST);
      if (step_ff == STEP_GRIP) begin
         w_raw = cfg.weight_grip;
         x_sel = $signed(x_g_ff);
         y_sel = $signed(filt_g_ff);
      end else begin
         if (j_idx == 3'd0) begin
            w_raw = cfg.weight_joint1;
         end else if (j_idx == 3'd2) begin
            w_raw = cfg.weight_joint3;
         end else begin
            w_raw = cfg.weight_main;
         end
         x_sel = $signed(x_j_ff[j_idx]);
         y_sel = $signed(filt_j_ff[j_idx]);
      end
      w_eff     = (w_raw > ONE_W) ? ONE_W : w_raw;
      diff      = 17'(x_sel) - 17'(y_sel);
      bprod     = $signed({1'b0, w_eff}) * diff;
      bacc      = (32'(y_sel) <<< jas_pkg::FRAC_BITS) + 32'(bprod)
                  + 32'(jas_pkg::HALF_Q);
      bshift    = bacc >>> jas_pkg::FRAC_BITS;
      blend_val = sat16(bshift[19:0]);
      grip_new  = (!gvalid_ff || (cfg.weight_grip >= ONE_W)) ? x_sel : blend_val;
      joint_new = !jvalid_ff ? x_sel : blend_val;

      unique case (j_idx)
         3'd0:    sbias = $signed(cfg.static_bias[15:0]);
         3'd2:    sbias = $signed(cfg.static_bias[31:16]);
         3'd3:    sbias = $signed(cfg.static_bias[47:32]);
         default: sbias = 16'sd0;
      endcase
      joint_biased = sat16(20'(joint_new) + 20'(sbias));
   end

   always_comb begin
      gd    = 17'($signed(filt_g_ff)) - OPEN17;
      num   = {gd[jas_pkg::AMT_W-1:0], {jas_pkg::FRAC_BITS{1'b0}}}
              + jas_pkg::NUM_W'(jas_pkg::GRASP_HALF);
      q_est = div_prod_ff[jas_pkg::RECIP_SHIFT +: jas_pkg::AMT_W];
      rem   = {1'b0, num} - 26'(q_est) * 26'(jas_pkg::GRASP_DEN);
      q_fix = (rem >= 26'(jas_pkg::GRASP_DEN)) ? q_est + 1'b1 : q_est;
      if ($signed(filt_g_ff) <= OPEN16) begin
         amt_calc = '0;
      end else if ($signed(filt_g_ff) >= CLOSE16) begin
         amt_calc = jas_pkg::AMT_W'(jas_pkg::ONE_Q);
      end else begin
         amt_calc = q_fix;
      end

      gb_idx      = 2'(step_ff - STEP_GRASP_FIRST);
      g_idx       = 3'({1'b0, gb_idx} + 3'd1);
      gbias       = $signed(cfg.grasp_bias[{gb_idx, 4'b0000} +: 16]);
      tprod       = $signed({1'b0, amt_ff}) * gbias;
      tsum        = 31'(tprod) + 31'(jas_pkg::HALF_Q);
      tshift      = tsum >>> jas_pkg::FRAC_BITS;
      term        = tshift[17:0];
      active      = (amt_ff > jas_pkg::AMT_W'(jas_pkg::GRASP_THRESH));
      joint_grasp = sat16(20'($signed(res_j_ff[g_idx])) + 20'(term));
      grip_sum    = 19'($signed(filt_g_ff)) + 19'(term);
      if (!active) begin
         grip_final = $signed(filt_g_ff);
      end else if (grip_sum < GMIN19) begin
         grip_final = GMIN19[15:0];
      end else if (grip_sum > GMAX19) begin
         grip_final = GMAX19[15:0];
      end else begin
         grip_final = grip_sum[15:0];
      end
   end

   always_comb begin
      st_in       = st_ff;
      step_in     = step_ff;
      x_j_in      = x_j_ff;
      x_g_in      = x_g_ff;
      filt_j_in   = filt_j_ff;
      filt_g_in   = filt_g_ff;
      jvalid_in   = jvalid_ff;
      gvalid_in   = gvalid_ff;
      res_j_in    = res_j_ff;
      div_prod_in = div_prod_ff;
      amt_in      = amt_ff;
      rsp_j_in    = rsp_j_ff;
      rsp_g_in    = rsp_g_ff;
      rsp_amt_in  = rsp_amt_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;
      head_pop    = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               if (head.load) begin
                  filt_j_in = head.joint;
                  filt_g_in = head.grip;
                  jvalid_in = 1'b1;
                  gvalid_in = 1'b1;
               end else begin
                  x_j_in  = head.joint;
                  x_g_in  = head.grip;
                  step_in = STEP_GRIP;
                  st_in   = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            step_in = step_ff + 4'd1;
            if (step_ff == STEP_GRIP) begin
               filt_g_in = grip_new;
               gvalid_in = 1'b1;
            end
            if (step_ff >= STEP_J_FIRST && step_ff <= STEP_J_LAST) begin
               filt_j_in[j_idx] = joint_new;
               res_j_in[j_idx]  = joint_biased;
               if (step_ff == STEP_J_LAST) begin
                  jvalid_in = 1'b1;
               end
            end
            if (step_ff == STEP_DIV) begin
               div_prod_in = 45'(num) * 45'(jas_pkg::RECIP);
            end
            if (step_ff == STEP_AMT) begin
               amt_in = amt_calc;
            end
            if (step_ff >= STEP_GRASP_FIRST && step_ff < STEP_FINAL && active) begin
               res_j_in[g_idx] = joint_grasp;
            end
            if (step_ff == STEP_FINAL) begin
               step_in = step_ff;
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_j_in     = res_j_ff;
                  rsp_g_in     = grip_final;
                  rsp_amt_in   = amt_ff;
                  rsp_valid_in = 1'b1;
                  st_in        = ST_IDLE;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         step_ff      <= STEP_GRIP;
         filt_j_ff    <= '0;
         filt_g_ff    <= '0;
         jvalid_ff    <= 1'b0;
         gvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         step_ff      <= step_in;
         filt_j_ff    <= filt_j_in;
         filt_g_ff    <= filt_g_in;
         jvalid_ff    <= jvalid_in;
         gvalid_ff    <= gvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_j_ff      <= x_j_in;
      x_g_ff      <= x_g_in;
      res_j_ff    <= res_j_in;
      div_prod_ff <= div_prod_in;
      amt_ff      <= amt_in;
      rsp_j_ff    <= rsp_j_in;
      rsp_g_ff    <= rsp_g_in;
      rsp_amt_ff  <= rsp_amt_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_joint  = rsp_j_ff;
   assign rsp_grip   = rsp_g_ff;
   assign rsp_amount = rsp_amt_ff;

endmodule

// ===== hw/rtl/joint_action_smoother.sv =====
// Joint action smoother. Each input transaction carries one robot action: six
// joint angles and a gripper angle, signed Q4.12 radians. An operation of one
// loads the filter state and yields no result; an operation of zero filters
// the action and yields one result transaction with the conditioned joints,
// the gripper command and the grasp amount (Q1.12).
// Input and result channels use valid/stall; a transaction moves on a rising
// edge with valid high and stall low. The configuration channel uses
// valid/ready (ready is always high); the user must write it only while the
// block is idle, which the block does not enforce. A two-entry queue decouples
// intake from the filter engine, and the result register lets the engine
// start the next action while a result waits. A filter action is popped from
// the queue head, then runs eleven sequencer steps over one shared blend
// unit: the gripper, the six joints with the grasp divide overlapping them,
// the joint grasp-bias steps and a final step that fills the result register.
// Loads set the filter state as popped, one per cycle while the engine idles.
// Reset clears the queue, the filter state and its first-sample flags, and
// returns the registers to their defaults. While the receiver stalls, the
// result holds and the engine waits at its last step; the queue then fills
// and the input channel stalls.
module joint_action_smoother (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_operation,
   input  logic signed [15:0]  req_joint1_in,
   input  logic signed [15:0]  req_joint2_in,
   input  logic signed [15:0]  req_joint3_in,
   input  logic signed [15:0]  req_joint4_in,
   input  logic signed [15:0]  req_joint5_in,
   input  logic signed [15:0]  req_joint6_in,
   input  logic signed [15:0]  req_grip_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_joint1_out,
   output logic signed [15:0]  rsp_joint2_out,
   output logic signed [15:0]  rsp_joint3_out,
   output logic signed [15:0]  rsp_joint4_out,
   output logic signed [15:0]  rsp_joint5_out,
   output logic signed [15:0]  rsp_joint6_out,
   output logic signed [15:0]  rsp_grip_out,
   output logic [12:0]         rsp_grasp_amount,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_wdata
);

   jas_pkg::cfg_type       cfg_ff, cfg_in;
   jas_pkg::joint_vec_type in_joint;
   jas_pkg::joint_vec_type out_joint;
   jas_pkg::item_type      head;
   logic                   head_valid;
   logic                   head_pop;
   logic                   csr_write;

   // The register file accepts a write in every cycle.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            jas_pkg::REG_WEIGHT_MAIN:   cfg_in.weight_main   = csr_wdata[12:0];
            jas_pkg::REG_WEIGHT_JOINT1: cfg_in.weight_joint1 = csr_wdata[12:0];
            jas_pkg::REG_WEIGHT_JOINT3: cfg_in.weight_joint3 = csr_wdata[12:0];
            jas_pkg::REG_WEIGHT_GRIP:   cfg_in.weight_grip   = csr_wdata[12:0];
            jas_pkg::REG_STATIC_BIAS:   cfg_in.static_bias   = csr_wdata[47:0];
            jas_pkg::REG_GRASP_BIAS:    cfg_in.grasp_bias    = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.weight_main   <= 13'd2048;
         cfg_ff.weight_joint1 <= 13'd2048;
         cfg_ff.weight_joint3 <= 13'd2048;
         cfg_ff.weight_grip   <= 13'd2458;
         cfg_ff.static_bias   <= '0;
         cfg_ff.grasp_bias    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign in_joint[0] = req_joint1_in;
   assign in_joint[1] = req_joint2_in;
   assign in_joint[2] = req_joint3_in;
   assign in_joint[3] = req_joint4_in;
   assign in_joint[4] = req_joint5_in;
   assign in_joint[5] = req_joint6_in;

   jas_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .in_operation (req_operation),
      .in_joint     (in_joint),
      .in_grip      (req_grip_in),
      .head_valid   (head_valid),
      .head         (head),
      .head_pop     (head_pop)
   );

   jas_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_joint  (out_joint),
      .rsp_grip   (rsp_grip_out),
      .rsp_amount (rsp_grasp_amount)
   );

   assign rsp_joint1_out = out_joint[0];
   assign rsp_joint2_out = out_joint[1];
   assign rsp_joint3_out = out_joint[2];
   assign rsp_joint4_out = out_joint[3];
   assign rsp_joint5_out = out_joint[4];
   assign rsp_joint6_out = out_joint[5];

endmodule

// ===== tb/sv/joint_action_smoother_tb.sv =====
module joint_action_smoother_tb;

   // Fixed-point constants of the smoother, Q4.12 angles and Q1.12 weights.
   localparam int     FRAC       = 12;
   localparam longint Q_ONE      = 4096;
   localparam longint Q_HALF     = 2048;
   // The grasp ramp runs from -1.10 rad (open) to -0.05 rad (closed).
   localparam longint RAMP_OPEN  = -4506;
   localparam longint RAMP_CLOSE = -205;
   localparam longint RAMP_SPAN  = RAMP_CLOSE - RAMP_OPEN;
   // The gripper command is held to -1.75..0.10 rad while grasping.
   localparam longint GRIP_LO    = -7168;
   localparam longint GRIP_HI    = 410;

   // Register indexes past the last register; writes to them must do nothing.
   localparam logic [2:0] REG_SPARE_LO = 3'd6;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   // Idle cycles waited after the last result, so that a trailing load
   // or filter still in flight has drained.
   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_CYCLES  = 30;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 275;
   // The long receiver hold-off, and the result count at which it starts.
   localparam int HOLD_AT       = 380;
   localparam int HOLD_CYCLES   = 400;

   // Channel 0..5 are joints 1..6 and channel 6 is the gripper.
   typedef struct packed {
      logic             op;
      logic [6:0][15:0] ch;
   } action_type;

   typedef struct packed {
      logic [6:0][15:0] ch;
      logic [12:0]      amount;
   } command_type;

   // A directed row either writes a register, sends an action whose
   // command comes from the predictor, or sends one with a known command.
   typedef enum logic [1:0] {
      ROW_REG,
      ROW_ACTION,
      ROW_KNOWN
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      action_type   act;
      command_type  want;
      logic [2:0]   idx;
      logic [63:0]  data;
   } dir_row_type;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic               req_operation    = jas_pkg::OP_FILTER;
   logic signed [15:0] req_joint1_in    = '0;
   logic signed [15:0] req_joint2_in    = '0;
   logic signed [15:0] req_joint3_in    = '0;
   logic signed [15:0] req_joint4_in    = '0;
   logic signed [15:0] req_joint5_in    = '0;
   logic signed [15:0] req_joint6_in    = '0;
   logic signed [15:0] req_grip_in      = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic signed [15:0] rsp_joint1_out;
   logic signed [15:0] rsp_joint2_out;
   logic signed [15:0] rsp_joint3_out;
   logic signed [15:0] rsp_joint4_out;
   logic signed [15:0] rsp_joint5_out;
   logic signed [15:0] rsp_joint6_out;
   logic signed [15:0] rsp_grip_out;
   logic [12:0]        rsp_grasp_amount;
   logic               csr_valid        = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index        = '0;
   logic [63:0]        csr_wdata        = '0;

   // The predictor's copy of the configuration, at its reset values.
   logic [12:0] w_main      = 13'd2048;
   logic [12:0] w_joint1    = 13'd2048;
   logic [12:0] w_joint3    = 13'd2048;
   logic [12:0] w_grip      = 13'd2458;
   logic [47:0] static_bias = '0;
   logic [63:0] grasp_bias  = '0;

   // The predictor's copy of the filter state. The primed flags record
   // whether each channel group has taken its first sample yet.
   logic signed [15:0] smooth_joint [6] = '{default: '0};
   logic signed [15:0] smooth_grip      = '0;
   bit                 joints_primed    = 1'b0;
   bit                 grip_primed      = 1'b0;

   // Commands still owed by the block, oldest first.
   command_type pending_cmds [$];
   dir_row_type dir_rows [$];

   int mismatches   = 0;
   int actions_sent = 0;
   int results_seen = 0;
   int cycle_count  = 0;
   int hold_left    = 0;
   bit hold_done    = 1'b0;

   joint_action_smoother u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_joint1_in    (req_joint1_in),
      .req_joint2_in    (req_joint2_in),
      .req_joint3_in    (req_joint3_in),
      .req_joint4_in    (req_joint4_in),
      .req_joint5_in    (req_joint5_in),
      .req_joint6_in    (req_joint6_in),
      .req_grip_in      (req_grip_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_joint1_out   (rsp_joint1_out),
      .rsp_joint2_out   (rsp_joint2_out),
      .rsp_joint3_out   (rsp_joint3_out),
      .rsp_joint4_out   (rsp_joint4_out),
      .rsp_joint5_out   (rsp_joint5_out),
      .rsp_joint6_out   (rsp_joint6_out),
      .rsp_grip_out     (rsp_grip_out),
      .rsp_grasp_amount (rsp_grasp_amount),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The run ends with a failure if it hangs for any reason.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("joint_action_smoother_tb NOT OK");
         $finish;
      end
   end

   // -----------------------------------------------------------------------
   // Predictor
   // -----------------------------------------------------------------------

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   // Weights above one behave as one.
   function automatic longint eff_weight(logic [12:0] w);
      return (w > Q_ONE) ? Q_ONE : longint'(w);
   endfunction

   // One low-pass step, y = w*x + (1-w)*y, rounded half up. The arithmetic
   // shift of a signed value is a floor, which is the rounding wanted here.
   function automatic longint blend_q(longint w, longint x, longint y);
      return clip16((w * x + (Q_ONE - w) * y + Q_HALF) >>> FRAC);
   endfunction

   function automatic longint grasp_term(longint amt, logic [15:0] bias);
      return (amt * longint'($signed(bias)) + Q_HALF) >>> FRAC;
   endfunction

   // Advances the filter state by one action and works out the command that
   // the block owes for it. Returns zero for a load, which owes nothing.
   function automatic bit smooth_action(input action_type a, output command_type c);
      longint x [7];
      longint amt;
      longint wg;
      longint w;
      int     i;
      c = '0;
      for (i = 0; i < 7; i++) x[i] = longint'($signed(a.ch[i]));

      if (a.op == jas_pkg::OP_LOAD) begin
         for (i = 0; i < 6; i++) smooth_joint[i] = 16'(x[i]);
         smooth_grip   = 16'(x[6]);
         joints_primed = 1'b1;
         grip_primed   = 1'b1;
         return 1'b0;
      end

      // The first sample after reset is taken as it is.
      if (!joints_primed) begin
         for (i = 0; i < 6; i++) smooth_joint[i] = 16'(x[i]);
         joints_primed = 1'b1;
      end else begin
         for (i = 0; i < 6; i++) begin
            w = eff_weight((i == 0) ? w_joint1 : (i == 2) ? w_joint3 : w_main);
            smooth_joint[i] = 16'(blend_q(w, x[i], smooth_joint[i]));
         end
      end
      for (i = 0; i < 6; i++) x[i] = smooth_joint[i];

      // A gripper weight of one lets the input straight through.
      wg = eff_weight(w_grip);
      if (!grip_primed || wg >= Q_ONE) begin
         smooth_grip = 16'(x[6]);
         grip_primed = 1'b1;
      end else begin
         smooth_grip = 16'(blend_q(wg, x[6], smooth_grip));
      end
      x[6] = smooth_grip;

      x[0] = clip16(x[0] + $signed(static_bias[15:0]));
      x[2] = clip16(x[2] + $signed(static_bias[31:16]));
      x[3] = clip16(x[3] + $signed(static_bias[47:32]));

      if (x[6] <= RAMP_OPEN) begin
         amt = 0;
      end else if (x[6] >= RAMP_CLOSE) begin
         amt = Q_ONE;
      end else begin
         amt = (((x[6] - RAMP_OPEN) <<< FRAC) + RAMP_SPAN / 2) / RAMP_SPAN;
      end

      // The grasp only acts above one thousandth of full closure.
      if (amt * 1000 > Q_ONE) begin
         x[1] = clip16(x[1] + grasp_term(amt, grasp_bias[15:0]));
         x[2] = clip16(x[2] + grasp_term(amt, grasp_bias[31:16]));
         x[3] = clip16(x[3] + grasp_term(amt, grasp_bias[47:32]));
         x[6] = x[6] + grasp_term(amt, grasp_bias[63:48]);
         if (x[6] < GRIP_LO) x[6] = GRIP_LO;
         if (x[6] > GRIP_HI) x[6] = GRIP_HI;
      end

      for (i = 0; i < 7; i++) c.ch[i] = 16'(x[i]);
      c.amount = 13'(amt);
      return 1'b1;
   endfunction

   // -----------------------------------------------------------------------
   // Drivers. Every task starts and ends just after a falling edge, where
   // the inputs change; handshakes are judged at the rising edge.
   // -----------------------------------------------------------------------

   // Neither side idles at random while this holds.
   function automatic bit quiet_now();
      return (actions_sent >= 700) && (actions_sent < 900);
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] data);
      // Registers may only change while the block is idle: every command
      // has come back, and any trailing load has had time to finish.
      while (pending_cmds.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         jas_pkg::REG_WEIGHT_MAIN:   w_main      = data[12:0];
         jas_pkg::REG_WEIGHT_JOINT1: w_joint1    = data[12:0];
         jas_pkg::REG_WEIGHT_JOINT3: w_joint3    = data[12:0];
         jas_pkg::REG_WEIGHT_GRIP:   w_grip      = data[12:0];
         jas_pkg::REG_STATIC_BIAS:   static_bias = data[47:0];
         jas_pkg::REG_GRASP_BIAS:    grasp_bias  = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Offers one action and waits until the block takes the transaction.
   // With known set, the command typed into the table is expected instead
   // of the predicted one; the predictor still runs to keep its state.
   task automatic send_action(input action_type a, input bit known, input command_type want);
      command_type guess;
      if (!quiet_now() && $urandom_range(99) < 36) begin
         req_valid = 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_operation = a.op;
      req_joint1_in = a.ch[0];
      req_joint2_in = a.ch[1];
      req_joint3_in = a.ch[2];
      req_joint4_in = a.ch[3];
      req_joint5_in = a.ch[4];
      req_joint6_in = a.ch[5];
      req_grip_in   = a.ch[6];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (smooth_action(a, guess)) begin
         pending_cmds.insert(pending_cmds.size(), known ? want : guess);
      end
      actions_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // The receiver stalls at random, except for the quiet stretch and one
   // long hold-off that backs the block up until its input stalls.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall = 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall = 1'b1;
      end else if (quiet_now()) begin
         rsp_stall = 1'b0;
      end else begin
         rsp_stall = ($urandom_range(99) < 36);
      end
   end

   // -----------------------------------------------------------------------
   // Result checking
   // -----------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_results
      command_type got;
      command_type want;
      string       fname;
      int          i;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         got.ch[0]  = rsp_joint1_out;
         got.ch[1]  = rsp_joint2_out;
         got.ch[2]  = rsp_joint3_out;
         got.ch[3]  = rsp_joint4_out;
         got.ch[4]  = rsp_joint5_out;
         got.ch[5]  = rsp_joint6_out;
         got.ch[6]  = rsp_grip_out;
         got.amount = rsp_grasp_amount;
         if (pending_cmds.size() == 0) begin
            report_mismatch("result transaction with no command outstanding");
         end else begin
            want = pending_cmds.pop_front();
            for (i = 0; i < 7; i++) begin
               if (got.ch[i] !== want.ch[i]) begin
                  fname = (i < 6) ? $sformatf("joint%0d_out", i + 1) : "grip_out";
                  report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                     results_seen, fname, $signed(got.ch[i]), $signed(want.ch[i])));
               end
            end
            if (got.amount !== want.amount) begin
               report_mismatch($sformatf("result %0d grasp_amount got %0d expected %0d",
                  results_seen, got.amount, want.amount));
            end
         end
      end
   end

   // -----------------------------------------------------------------------
   // Stimulus
   // -----------------------------------------------------------------------

   function automatic void dir_act(input logic op, input int j1, input int j2,
                                   input int j3, input int j4, input int j5,
                                   input int j6, input int g);
      dir_row_type r;
      r = '0;
      r.kind     = ROW_ACTION;
      r.act.op   = op;
      r.act.ch[0] = j1[15:0];
      r.act.ch[1] = j2[15:0];
      r.act.ch[2] = j3[15:0];
      r.act.ch[3] = j4[15:0];
      r.act.ch[4] = j5[15:0];
      r.act.ch[5] = j6[15:0];
      r.act.ch[6] = g[15:0];
      dir_rows.insert(dir_rows.size(), r);
   endfunction

   // Gives the row just added a command typed in by hand.
   function automatic void dir_want(input int j1, input int j2, input int j3,
                                    input int j4, input int j5, input int j6,
                                    input int g, input int amt);
      dir_row_type r;
      r = dir_rows[dir_rows.size() - 1];
      r.kind        = ROW_KNOWN;
      r.want.ch[0]  = j1[15:0];
      r.want.ch[1]  = j2[15:0];
      r.want.ch[2]  = j3[15:0];
      r.want.ch[3]  = j4[15:0];
      r.want.ch[4]  = j5[15:0];
      r.want.ch[5]  = j6[15:0];
      r.want.ch[6]  = g[15:0];
      r.want.amount = amt[12:0];
      dir_rows[dir_rows.size() - 1] = r;
   endfunction

   function automatic void dir_reg(input logic [2:0] idx, input logic [63:0] data);
      dir_row_type r;
      r = '0;
      r.kind = ROW_REG;
      r.idx  = idx;
      r.data = data;
      dir_rows.insert(dir_rows.size(), r);
   endfunction

   // Weights favor the ends of the range and the values past one.
   function automatic logic [12:0] rand_weight();
      case ($urandom_range(7))
         0:       return 13'd0;
         1:       return 13'd4096;
         2:       return 13'h1FFF;
         3:       return 13'd4097;
         4:       return 13'd1;
         5:       return 13'($urandom_range(8191));
         default: return 13'($urandom_range(4096));
      endcase
   endfunction

   // One packed bias: an extreme, a modest value, or anything at all.
   function automatic logic [15:0] rand_lane();
      case ($urandom_range(5))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'($urandom_range(2000) - 1000);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic action_type rand_action();
      action_type a;
      int         i;
      a.op = ($urandom_range(99) < 12) ? jas_pkg::OP_LOAD : jas_pkg::OP_FILTER;
      for (i = 0; i < 6; i++) begin
         a.ch[i] = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(16383) - 8192);
      end
      // Most gripper angles sit on or near the grasp ramp so that the
      // threshold, the ramp ends and the clamp all see plenty of traffic.
      case ($urandom_range(3))
         0:       a.ch[6] = 16'($urandom);
         1:       a.ch[6] = 16'(-4700 + int'($urandom_range(5400)));
         2:       a.ch[6] = 16'(-4512 + int'($urandom_range(16)));
         default: a.ch[6] = 16'(-7400 + int'($urandom_range(3000)));
      endcase
      return a;
   endfunction

   initial begin : stimulus
      dir_row_type row;
      action_type  a;
      int          phase;

      // Default weights. The first filter transaction after reset must
      // come back unchanged, since every channel takes its first sample
      // as it is; the gripper at full scale open gives no grasp.
      dir_act(jas_pkg::OP_FILTER, 32767, -32768, 32767, -32768, 32767, -32768, -32768);
      dir_want(32767, -32768, 32767, -32768, 32767, -32768, -32768, 0);
      dir_act(jas_pkg::OP_FILTER, 100, -100, 4096, -4096, 0, 1, -4506);
      dir_act(jas_pkg::OP_FILTER, -32768, 32767, -32768, 32767, -1, 0, 32767);
      // Each load sets the state so that the following filter transaction
      // lands exactly on a point of interest of the grasp ramp: the open
      // end, just under and just over the action threshold, the closed
      // end, and far past it where the gripper clamp bites.
      dir_act(jas_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, -4506);
      dir_act(jas_pkg::OP_FILTER, 1, 2, 3, 4, 5, 6, -4506);
      dir_act(jas_pkg::OP_LOAD, -7, 7, -7, 7, -7, 7, -4502);
      dir_act(jas_pkg::OP_FILTER, -7, 7, -7, 7, -7, 7, -4502);
      dir_act(jas_pkg::OP_LOAD, 500, 500, 500, 500, 500, 500, -4501);
      dir_act(jas_pkg::OP_FILTER, 501, 499, 502, 498, 503, 497, -4501);
      dir_act(jas_pkg::OP_LOAD, 0, 0, 0, 0, 0, 0, -205);
      dir_act(jas_pkg::OP_FILTER, 3, -3, 3, -3, 3, -3, -205);
      dir_act(jas_pkg::OP_LOAD, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
      dir_act(jas_pkg::OP_FILTER, -32768, -32768, -32768, -32768, -32768, -32768,
              32767);

      // Weights at and past one make every channel pass straight through.
      // The bias lanes are at their extremes or zero, so that sums saturate or cancel,
      // and the bits above each register's width must be dropped.
      dir_reg(jas_pkg::REG_WEIGHT_MAIN, 64'hFFFF_FFFF_FFFF_FFFF);
      dir_reg(jas_pkg::REG_WEIGHT_JOINT1, 64'd4096);
      dir_reg(jas_pkg::REG_WEIGHT_JOINT3, 64'd4097);
      dir_reg(jas_pkg::REG_WEIGHT_GRIP, 64'd4096);
      dir_reg(jas_pkg::REG_STATIC_BIAS, 64'hFFFF_7FFF_8000_7FFF);
      dir_reg(jas_pkg::REG_GRASP_BIAS, 64'h8000_8000_0000_7FFF);
      dir_reg(REG_SPARE_LO, 64'h0123_4567_89AB_CDEF);
      dir_reg(REG_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF);
      dir_act(jas_pkg::OP_FILTER, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
      dir_want(32767, 32767, -1, -1, 32767, 32767, -1, 4096);
      dir_act(jas_pkg::OP_FILTER, -32768, -32768, -32768, -32768, -32768, -32768,
              -32768);
      dir_want(-1, -32768, -32768, -1, -32768, -32768, -32768, 0);
      dir_act(jas_pkg::OP_FILTER, 1000, -1000, 0, 0, 2000, -2000, -2000);
      dir_act(jas_pkg::OP_FILTER, -5, 5, -5, 5, -5, 5, 200);

      // Zero weights freeze every channel at its present value.
      dir_reg(jas_pkg::REG_WEIGHT_MAIN, 64'd0);
      dir_reg(jas_pkg::REG_WEIGHT_JOINT1, 64'd0);
      dir_reg(jas_pkg::REG_WEIGHT_JOINT3, 64'd0);
      dir_reg(jas_pkg::REG_WEIGHT_GRIP, 64'd0);
      dir_act(jas_pkg::OP_FILTER, 12345, -12345, 23456, -23456, 111, -111, -3000);
      dir_act(jas_pkg::OP_FILTER, -1, 1, -1, 1, -1, 1, -4000);

      // Reset is released on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[k]) begin
         row = dir_rows[k];
         case (row.kind)
            ROW_REG:    csr_write(row.idx, row.data);
            ROW_KNOWN:  send_action(row.act, 1'b1, row.want);
            default:    send_action(row.act, 1'b0, '0);
         endcase
      end

      // Random phases, each under a fresh configuration. Weight writes
      // carry random upper bits that the block must ignore.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         csr_write(jas_pkg::REG_WEIGHT_MAIN, {$urandom, 19'($urandom), rand_weight()});
         csr_write(jas_pkg::REG_WEIGHT_JOINT1, {$urandom, 19'($urandom), rand_weight()});
         csr_write(jas_pkg::REG_WEIGHT_JOINT3, {$urandom, 19'($urandom), rand_weight()});
         csr_write(jas_pkg::REG_WEIGHT_GRIP, {$urandom, 19'($urandom), rand_weight()});
         csr_write(jas_pkg::REG_STATIC_BIAS,
                   {16'($urandom), rand_lane(), rand_lane(), rand_lane()});
         csr_write(jas_pkg::REG_GRASP_BIAS,
                   {rand_lane(), rand_lane(), rand_lane(), rand_lane()});
         if ($urandom_range(1)) begin
            csr_write($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, {$urandom, $urandom});
         end
         repeat (PHASE_ITEMS) begin
            a = rand_action();
            send_action(a, 1'b0, '0);
         end
      end

      // Wait for every owed command, then give stray results time to show.
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("joint_action_smoother_tb OK");
      end else begin
         $display("joint_action_smoother_tb NOT OK");
      end
      $finish;
   end

endmodule
